// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks for the RTL, disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffl_pkg.sv =====
// ---------------------------------------------------------------------------
// ffl_pkg
// Types and constants of the first-fit free-list allocator.
// ---------------------------------------------------------------------------
`default_nettype none

package ffl_pkg;

  localparam int unsigned SIZE_BITS = 33;

  localparam logic [SIZE_BITS-1:0] HDR_BYTES = SIZE_BITS'(8);
  localparam logic [SIZE_BITS-1:0] MIN_KEEP  = SIZE_BITS'(24);

  localparam logic [15:0] LARGE_LIMIT_RST = 16'd4096;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] request_size;
    logic [47:0] block_address;
  } ffl_in_t;

  typedef struct packed {
    logic        granted;
    logic        fallback;
    logic [47:0] user_address;
    logic        dropped;
    logic [6:0]  held_count;
  } ffl_out_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
    logic cmp_en;
  } ffl_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/first_fit_free_list_allocator_top.sv =====
// ---------------------------------------------------------------------------
// first_fit_free_list_allocator_top
// First-fit free-list allocator built as a row of shifting list cells.
// ---------------------------------------------------------------------------
// Holds up to LIST_ENTRIES free blocks, newest at cell 0. One request is in
// work at a time; a result moves to an output register so the next request
// is taken while it waits. A free that keeps its block passes through the
// shift step; one that keeps nothing (null pointer, small block or full list)
// and an allocate above large_limit go straight to the result. Any other
// allocate passes the compare, first-fit pick and entry read steps of the
// cell row; with no fit it ends there, and a grant goes on through the
// leftover and shift steps. While the output register holds an unaccepted
// result, a finished request waits and the input stays stalled. No clearing
// pass after reset: cells past the count are never read.
`default_nettype none

`include "assert_macros.svh"

module first_fit_free_list_allocator_top #(
  parameter int unsigned LIST_ENTRIES = 64,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ffl_pkg::ffl_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ffl_pkg::ffl_out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);
  import ffl_pkg::*;

  localparam int unsigned CW = $clog2(LIST_ENTRIES + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_SEL  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_LFT  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [15:0]          large_limit_r;
  logic                 grant_op_r, grant_op_nxt;
  logic                 keep_r, keep_nxt;
  logic [SIZE_BITS-1:0] total_r, total_nxt;
  logic [ADDR_BITS-1:0] head_addr_r, head_addr_nxt;
  logic [SIZE_BITS-1:0] head_size_r, head_size_nxt;
  ffl_out_t             res_r, res_nxt;
  ffl_out_t             out_r;
  logic                 out_valid_r;

  logic                 accept;
  logic                 full;
  logic [SIZE_BITS-1:0] in_total;
  logic [ADDR_BITS+47:0] ptr_wide;
  logic [ADDR_BITS-1:0] ptr_a;
  logic [ADDR_BITS+SIZE_BITS-1:0] total_wide;
  logic [ADDR_BITS-1:0] total_a;
  logic [ADDR_BITS-1:0] uaddr_a;
  logic [ADDR_BITS+47:0] uaddr_wide;
  logic [SIZE_BITS-1:0] leftover;
  logic [CW+6:0]        count_wide;

  ffl_cell_ctrl_t        ctrl [LIST_ENTRIES];
  logic [ADDR_BITS-1:0]  cell_addr [LIST_ENTRIES];
  logic [SIZE_BITS-1:0]  cell_size [LIST_ENTRIES];
  logic [LIST_ENTRIES-1:0] hit;

  logic                    found;
  logic [LIST_ENTRIES-1:0] onehot;
  logic [LIST_ENTRIES-1:0] below;
  logic [ADDR_BITS-1:0]    sel_addr;
  logic [SIZE_BITS-1:0]    sel_size;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign full      = (count_r == CW'(LIST_ENTRIES));

  assign in_total   = {1'b0, in_data.request_size} + HDR_BYTES;
  assign ptr_wide   = {{ADDR_BITS{1'b0}}, in_data.block_address};
  assign ptr_a      = ptr_wide[ADDR_BITS-1:0];
  assign total_wide = {{ADDR_BITS{1'b0}}, total_r};
  assign total_a    = total_wide[ADDR_BITS-1:0];
  assign uaddr_a    = sel_addr + ADDR_BITS'(HDR_BYTES);
  assign uaddr_wide = {{48{1'b0}}, uaddr_a};
  assign leftover   = sel_size - total_r;
  assign count_wide = {7'd0, count_nxt};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    grant_op_nxt  = grant_op_r;
    keep_nxt      = keep_r;
    total_nxt     = total_r;
    head_addr_nxt = head_addr_r;
    head_size_nxt = head_size_r;
    res_nxt       = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt       = '0;
          total_nxt     = in_total;
          grant_op_nxt  = 1'b0;
          keep_nxt      = 1'b0;
          head_addr_nxt = ptr_a - ADDR_BITS'(HDR_BYTES);
          head_size_nxt = in_total;
          if (in_data.mode == MODE_ALLOC) begin
            if ({1'b0, in_data.request_size} > {17'd0, large_limit_r}) begin
              res_nxt.fallback = 1'b1;
              state_nxt        = ST_DONE;
            end else begin
              state_nxt = ST_CMP;
            end
          end else if ((in_data.block_address == '0) || (in_total <= MIN_KEEP)) begin
            state_nxt = ST_DONE;
          end else if (full) begin
            res_nxt.dropped = 1'b1;
            state_nxt       = ST_DONE;
          end else begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_CMP: state_nxt = ST_SEL;
      ST_SEL: state_nxt = ST_RD;
      ST_RD: begin
        if (found) begin
          state_nxt = ST_LFT;
        end else begin
          res_nxt.fallback = 1'b1;
          state_nxt        = ST_DONE;
        end
      end
      ST_LFT: begin
        grant_op_nxt         = 1'b1;
        keep_nxt             = (leftover > MIN_KEEP);
        head_addr_nxt        = sel_addr + total_a;
        head_size_nxt        = leftover;
        res_nxt.granted      = 1'b1;
        res_nxt.user_address = uaddr_wide[47:0];
        state_nxt            = ST_UPD;
      end
      ST_UPD: begin
        if (!grant_op_r) begin
          count_nxt = count_r + CW'(1);
        end else if (!keep_r) begin
          count_nxt = count_r - CW'(1);
        end
        res_nxt.held_count = count_wide[6:0];
        state_nxt          = ST_DONE;
      end
      ST_DONE: begin
        res_nxt.held_count = count_wide[6:0];
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      count_r       <= '0;
      large_limit_r <= LARGE_LIMIT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        large_limit_r <= cfg_data;
      end
      if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    grant_op_r  <= grant_op_nxt;
    keep_r      <= keep_nxt;
    total_r     <= total_nxt;
    head_addr_r <= head_addr_nxt;
    head_size_r <= head_size_nxt;
    res_r       <= res_nxt;
    if ((state_r == ST_DONE) && (!out_valid_r || out_ready)) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Cell row
  for (genvar i = 0; i < LIST_ENTRIES; i++) begin : g_cell
    logic [ADDR_BITS-1:0] l_addr, r_addr;
    logic [SIZE_BITS-1:0] l_size, r_size;

    if (i == 0) begin : g_head
      assign l_addr = head_addr_r;
      assign l_size = head_size_r;
    end else begin : g_mid
      assign l_addr = cell_addr[i-1];
      assign l_size = cell_size[i-1];
    end

    if (i == LIST_ENTRIES - 1) begin : g_tail
      assign r_addr = cell_addr[i];
      assign r_size = cell_size[i];
    end else begin : g_body
      assign r_addr = cell_addr[i+1];
      assign r_size = cell_size[i+1];
    end

    always_comb begin
      ctrl[i].cmp_en     = (state_r == ST_CMP);
      ctrl[i].take_left  = 1'b0;
      ctrl[i].take_right = 1'b0;
      if (state_r == ST_UPD) begin
        if (!grant_op_r) begin
          ctrl[i].take_left = 1'b1;
        end else if (keep_r) begin
          ctrl[i].take_left = below[i] || onehot[i];
        end else begin
          ctrl[i].take_right = !below[i];
        end
      end
    end

    ffl_cell #(
      .ADDR_BITS(ADDR_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl[i]),
      .valid     (count_r > CW'(i)),
      .need      (total_r),
      .left_addr (l_addr),
      .left_size (l_size),
      .right_addr(r_addr),
      .right_size(r_size),
      .addr      (cell_addr[i]),
      .size      (cell_size[i]),
      .hit       (hit[i])
    );
  end

  ffl_pick #(
    .LIST_ENTRIES(LIST_ENTRIES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .pick_en  (state_r == ST_SEL),
    .read_en  (state_r == ST_RD),
    .hit      (hit),
    .cell_addr(cell_addr),
    .cell_size(cell_size),
    .found    (found),
    .onehot   (onehot),
    .below    (below),
    .sel_addr (sel_addr),
    .sel_size (sel_size)
  );

  // Checks
  `ASSERT_CLK(a_count_bound, count_r <= CW'(LIST_ENTRIES), "entry count above capacity")
  `ASSERT_CLK(a_pick_onehot, $onehot0(onehot), "first-fit pick not one-hot")
  `ASSERT_CLK(a_flags_excl, !(out_valid && out_data.granted && out_data.fallback),
              "granted and fallback both set")
  `ASSERT_NEXT(a_one_item, accept, !in_ready, "second transfer while busy")

endmodule

`default_nettype wire

// ===== rtl/ffl_cell.sv =====
// ---------------------------------------------------------------------------
// ffl_cell
// One free-list entry: shifts from either neighbor and flags a size fit.
// ---------------------------------------------------------------------------
`default_nettype none

module ffl_cell #(
  parameter int unsigned ADDR_BITS = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ffl_pkg::ffl_cell_ctrl_t        ctrl,
  input  wire logic                           valid,
  input  wire logic [ffl_pkg::SIZE_BITS-1:0]  need,
  input  wire logic [ADDR_BITS-1:0]           left_addr,
  input  wire logic [ffl_pkg::SIZE_BITS-1:0]  left_size,
  input  wire logic [ADDR_BITS-1:0]           right_addr,
  input  wire logic [ffl_pkg::SIZE_BITS-1:0]  right_size,
  output logic      [ADDR_BITS-1:0]           addr,
  output logic      [ffl_pkg::SIZE_BITS-1:0]  size,
  output logic                                hit
);
  import ffl_pkg::*;

  logic [ADDR_BITS-1:0] addr_r;
  logic [SIZE_BITS-1:0] size_r;
  logic                 hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.take_left) begin
      addr_r <= left_addr;
      size_r <= left_size;
    end else if (ctrl.take_right) begin
      addr_r <= right_addr;
      size_r <= right_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      hit_r <= valid && (size_r >= need);
    end
  end

  assign addr = addr_r;
  assign size = size_r;
  assign hit  = hit_r;

endmodule

`default_nettype wire

// ===== rtl/ffl_pick.sv =====
// ---------------------------------------------------------------------------
// ffl_pick
// First-fit pick over the cell row and readout of the chosen entry.
// ---------------------------------------------------------------------------
`default_nettype none

module ffl_pick #(
  parameter int unsigned LIST_ENTRIES = 64,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           pick_en,
  input  wire logic                           read_en,
  input  wire logic [LIST_ENTRIES-1:0]        hit,
  input  wire logic [ADDR_BITS-1:0]           cell_addr [LIST_ENTRIES],
  input  wire logic [ffl_pkg::SIZE_BITS-1:0]  cell_size [LIST_ENTRIES],
  output logic                                found,
  output logic      [LIST_ENTRIES-1:0]        onehot,
  output logic      [LIST_ENTRIES-1:0]        below,
  output logic      [ADDR_BITS-1:0]           sel_addr,
  output logic      [ffl_pkg::SIZE_BITS-1:0]  sel_size
);
  import ffl_pkg::*;

  logic [LIST_ENTRIES-1:0] onehot_r;
  logic [LIST_ENTRIES-1:0] below_r;
  logic                    found_r;
  logic [ADDR_BITS-1:0]    sel_addr_r;
  logic [SIZE_BITS-1:0]    sel_size_r;
  logic [ADDR_BITS-1:0]    mux_addr;
  logic [SIZE_BITS-1:0]    mux_size;

  always_comb begin
    mux_addr = '0;
    mux_size = '0;
    for (int i = 0; i < LIST_ENTRIES; i++) begin
      mux_addr = mux_addr | (cell_addr[i] & {ADDR_BITS{onehot_r[i]}});
      mux_size = mux_size | (cell_size[i] & {SIZE_BITS{onehot_r[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onehot_r <= '0;
      found_r  <= 1'b0;
    end else if (pick_en) begin
      onehot_r <= hit & (~hit + LIST_ENTRIES'(1));
      found_r  <= |hit;
    end
  end

  always_ff @(posedge clk) begin
    if (read_en) begin
      sel_addr_r <= mux_addr;
      sel_size_r <= mux_size;
      below_r    <= onehot_r - LIST_ENTRIES'(1);
    end
  end

  assign found    = found_r;
  assign onehot   = onehot_r;
  assign below    = below_r;
  assign sel_addr = sel_addr_r;
  assign sel_size = sel_size_r;

endmodule

`default_nettype wire
